@@ rtl/rvq_pkg.sv @@
`timescale 1ns / 1ps
package rvq_pkg;

   localparam int RotW   = 16;
   localparam int SumW   = 32;
   localparam int RadW   = 40;
   localparam int RootW  = 20;
   localparam int AngW   = 36;
   localparam int CorW   = 34;
   localparam int QuoW   = 17;
   localparam int DvdW   = 36;
   localparam int ProdW  = RotW + CorW;
   localparam int AtanEntries = 24;
   localparam int OneQ14 = 16384;

   localparam logic signed [AngW-1:0] PiQ30     = 36'sd3373259426;
   localparam logic signed [AngW-1:0] HalfPiQ30 = 36'sd1686629713;
   localparam logic signed [AngW-1:0] TwoPiQ30  = 36'sd6746518852;
   localparam logic signed [CorW-1:0] GainInvQ30 = 34'sh26DD3B6A;

   localparam logic [31:0] AtanTable [AtanEntries] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
      32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
      32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
      32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

   typedef struct packed {
      logic signed [RotW-1:0] rot_x;
      logic signed [RotW-1:0] rot_y;
      logic signed [RotW-1:0] rot_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [RotW-1:0] quat_w;
      logic signed [RotW-1:0] quat_x;
      logic signed [RotW-1:0] quat_y;
      logic signed [RotW-1:0] quat_z;
   } rsp_payload_type;

   typedef struct packed {
      req_payload_type  vec;
      logic             zero;
      logic [RootW-1:0] root;
   } sqrt_out_type;

   typedef struct packed {
      sqrt_out_type           base;
      logic signed [RotW-1:0] w;
      logic signed [CorW-1:0] sine;
   } cordic_out_type;

   function automatic logic signed [RotW-1:0] sat_q14(input logic signed [AngW-1:0] v);
      logic signed [AngW-1:0] lim;
      lim = AngW'(OneQ14);
      if (v > lim) begin
         return RotW'(OneQ14);
      end else if (v < -lim) begin
         return -RotW'(OneQ14);
      end
      return v[RotW-1:0];
   endfunction

endpackage

@@ rtl/rotation_vector_to_quaternion_unit.sv @@
`timescale 1ns / 1ps
// channel   ports                           bits  carries
// request   req_valid, req_stall, req_data   48    rotation vector, Q3.12
// response  rsp_valid, rsp_stall, rsp_data   64    unit quaternion, Q1.14
//
// one request per cycle while req_stall is low
// pipeline depths: square root (22), cordic (CORDIC_STAGES + 3) and
// divider (21)
// reset clears the valid bits only
// rsp_stall holds full stages; empty stages keep filling, so requests are
// taken until every stage holds one
module rotation_vector_to_quaternion_unit
   import rvq_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   logic           sqrt_ready;
   logic           sqrt_valid;
   sqrt_out_type   sqrt_data;
   logic           cordic_ready;
   logic           cordic_valid;
   cordic_out_type cordic_data;
   logic           div_ready;

   assign req_stall = !sqrt_ready;

   rvq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (sqrt_ready),
      .in_data   (req_data),
      .out_valid (sqrt_valid),
      .out_ready (cordic_ready),
      .out_data  (sqrt_data)
   );

   rvq_cordic #(
      .Stages (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sqrt_valid),
      .in_ready  (cordic_ready),
      .in_data   (sqrt_data),
      .out_valid (cordic_valid),
      .out_ready (div_ready),
      .out_data  (cordic_data)
   );

   rvq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cordic_valid),
      .in_ready  (div_ready),
      .in_data   (cordic_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.quat_w <= OneQ14 && rsp_data.quat_w >= -OneQ14))
      else $error("quat_w beyond unit range");

   a_xyz_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.quat_x <= OneQ14 && rsp_data.quat_x >= -OneQ14 &&
                     rsp_data.quat_y <= OneQ14 && rsp_data.quat_y >= -OneQ14 &&
                     rsp_data.quat_z <= OneQ14 && rsp_data.quat_z >= -OneQ14))
      else $error("vector part beyond unit range");
`endif

endmodule

@@ rtl/rvq_sqrt.sv @@
`timescale 1ns / 1ps
module rvq_sqrt
   import rvq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  req_payload_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output sqrt_out_type    out_data
);

   localparam int NStg = RootW + 2;
   localparam int RemW = RootW + 3;

   logic [NStg:0]   stage_en;
   logic [NStg-1:0] valid_ff;
   logic [NStg-1:0] valid_in;

   logic signed [2*RotW-1:0] sqx_in, sqy_in, sqz_in;
   logic [2*RotW-2:0] sq_ff [3];
   req_payload_type   vec0_ff;
   logic [SumW-1:0]   sum_in;

   logic [RemW-1:0]  rem_ff  [RootW+1];
   logic [RootW-1:0] root_ff [RootW+1];
   logic [RadW-1:0]  rad_ff  [RootW+1];
   req_payload_type  vec_ff  [RootW+1];
   logic             zero_ff [RootW+1];

   assign stage_en[NStg] = out_ready;
   assign in_ready       = stage_en[0];
   assign valid_in       = {valid_ff[NStg-2:0], in_valid};

   for (genvar k = 0; k < NStg; k++) begin : g_en
      assign stage_en[k] = !valid_ff[k] || stage_en[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NStg; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // squares
   always_comb begin
      sqx_in = in_data.rot_x * in_data.rot_x;
      sqy_in = in_data.rot_y * in_data.rot_y;
      sqz_in = in_data.rot_z * in_data.rot_z;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sq_ff[0] <= sqx_in[2*RotW-2:0];
         sq_ff[1] <= sqy_in[2*RotW-2:0];
         sq_ff[2] <= sqz_in[2*RotW-2:0];
         vec0_ff  <= in_data;
      end
   end

   // sum of squares, radicand scaled by 2^8
   assign sum_in = SumW'(sq_ff[0]) + SumW'(sq_ff[1]) + SumW'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         rad_ff[0]  <= {sum_in, 8'h00};
         vec_ff[0]  <= vec0_ff;
         zero_ff[0] <= (sum_in == '0);
      end
   end

   // one root bit per stage
   for (genvar r = 1; r <= RootW; r++) begin : g_root
      logic [RemW-1:0] rem_sh, trial, rem_in;
      logic            take;
      always_comb begin
         rem_sh = {rem_ff[r-1][RemW-3:0], rad_ff[r-1][RadW-1:RadW-2]};
         trial  = {1'b0, root_ff[r-1], 2'b01};
         take   = (rem_sh >= trial);
         rem_in = take ? rem_sh - trial : rem_sh;
      end
      always_ff @(posedge clock) begin
         if (stage_en[r+1]) begin
            rem_ff[r]  <= rem_in;
            root_ff[r] <= {root_ff[r-1][RootW-2:0], take};
            rad_ff[r]  <= {rad_ff[r-1][RadW-3:0], 2'b00};
            vec_ff[r]  <= vec_ff[r-1];
            zero_ff[r] <= zero_ff[r-1];
         end
      end
   end

   assign out_valid = valid_ff[NStg-1];

   always_comb begin
      out_data.vec  = vec_ff[RootW];
      out_data.zero = zero_ff[RootW];
      out_data.root = root_ff[RootW];
   end

endmodule

@@ rtl/rvq_cordic.sv @@
`timescale 1ns / 1ps
module rvq_cordic
   import rvq_pkg::*;
#(
   parameter int Stages = 16
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  sqrt_out_type   in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output cordic_out_type out_data
);

   localparam int NStg = Stages + 3;
   localparam logic signed [CorW-1:0] WRound = CorW'(32768);

   logic [NStg:0]   stage_en;
   logic [NStg-1:0] valid_ff;
   logic [NStg-1:0] valid_in;

   sqrt_out_type side_ff [NStg];

   logic signed [AngW-1:0] half_ang, ang_in, ang_ff, fold_ang;
   logic                   flip_in;

   logic signed [CorW-1:0] x_ff [Stages+1];
   logic signed [CorW-1:0] y_ff [Stages+1];
   logic signed [CorW-1:0] z_ff [Stages+1];
   logic                   flip_ff [Stages+1];

   logic signed [CorW-1:0] cos_f, sin_f, wsum;
   logic signed [RotW-1:0] w_ff;
   logic signed [CorW-1:0] sine_ff;

   assign stage_en[NStg] = out_ready;
   assign in_ready       = stage_en[0];
   assign valid_in       = {valid_ff[NStg-2:0], in_valid};

   for (genvar k = 0; k < NStg; k++) begin : g_en
      assign stage_en[k] = !valid_ff[k] || stage_en[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NStg; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         side_ff[0] <= in_data;
      end
   end

   for (genvar k = 1; k < NStg; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // one period reduction of the half angle
   always_comb begin
      half_ang = $signed({3'b000, in_data.root, 13'h0000});
      ang_in   = (half_ang > PiQ30) ? half_ang - TwoPiQ30 : half_ang;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         ang_ff <= ang_in;
      end
   end

   // fold into the right half plane
   always_comb begin
      priority if (ang_ff > HalfPiQ30) begin
         fold_ang = ang_ff - PiQ30;
         flip_in  = 1'b1;
      end else if (ang_ff < -HalfPiQ30) begin
         fold_ang = ang_ff + PiQ30;
         flip_in  = 1'b1;
      end else begin
         fold_ang = ang_ff;
         flip_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         x_ff[0]    <= GainInvQ30;
         y_ff[0]    <= '0;
         z_ff[0]    <= fold_ang[CorW-1:0];
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < Stages; i++) begin : g_iter
      logic signed [CorW-1:0] dx, dy, da;
      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         da = $signed({{(CorW-32){1'b0}}, AtanTable[i]});
      end
      always_ff @(posedge clock) begin
         if (stage_en[i+2]) begin
            if (!z_ff[i][CorW-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - da;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + da;
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   always_comb begin
      cos_f = flip_ff[Stages] ? -x_ff[Stages] : x_ff[Stages];
      sin_f = flip_ff[Stages] ? -y_ff[Stages] : y_ff[Stages];
      wsum  = cos_f + WRound;
   end

   always_ff @(posedge clock) begin
      if (stage_en[NStg-1]) begin
         w_ff    <= sat_q14(AngW'(wsum >>> 16));
         sine_ff <= sin_f;
      end
   end

   assign out_valid = valid_ff[NStg-1];

   always_comb begin
      out_data.base = side_ff[NStg-1];
      out_data.w    = w_ff;
      out_data.sine = sine_ff;
   end

`ifndef SYNTHESIS
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> (z_ff[0] <= HalfPiQ30 && z_ff[0] >= -HalfPiQ30))
      else $error("folded angle out of range");
`endif

endmodule

@@ rtl/rvq_div.sv @@
`timescale 1ns / 1ps
module rvq_div
   import rvq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  cordic_out_type  in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_payload_type out_data
);

   localparam int NStg = QuoW + 4;

   typedef struct packed {
      logic signed [RotW-1:0] w;
      logic                   zero;
      logic [RootW-1:0]       root;
      logic [2:0]             neg;
   } dside_type;

   logic [NStg:0]   stage_en;
   logic [NStg-1:0] valid_ff;
   logic [NStg-1:0] valid_in;

   dside_type side_ff [NStg-1];
   dside_type side0_in;
   dside_type side1_in;

   logic signed [RotW-1:0]  comp [3];
   logic signed [ProdW-1:0] prod_in [3];
   logic signed [ProdW-1:0] prod_ff [3];
   logic signed [ProdW-1:0] abs_in  [3];
   logic [2:0]              neg_in;
   logic [ProdW-2:0]        mag_ff  [3];
   logic [ProdW-1:0]        nsum    [3];
   logic [DvdW-1:0]         dvd     [3];

   logic [RootW-1:0] rem_ff [QuoW+1][3];
   logic [QuoW-1:0]  dq_ff  [QuoW+1][3];

   logic signed [QuoW:0]   sq [3];
   rsp_payload_type        res_ff;

   assign stage_en[NStg] = out_ready;
   assign in_ready       = stage_en[0];
   assign valid_in       = {valid_ff[NStg-2:0], in_valid};

   for (genvar k = 0; k < NStg; k++) begin : g_en
      assign stage_en[k] = !valid_ff[k] || stage_en[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NStg; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // vector component times sine
   always_comb begin
      comp[0] = in_data.base.vec.rot_x;
      comp[1] = in_data.base.vec.rot_y;
      comp[2] = in_data.base.vec.rot_z;
      for (int l = 0; l < 3; l++) begin
         prod_in[l] = comp[l] * in_data.sine;
      end
      side0_in.w    = in_data.w;
      side0_in.zero = in_data.base.zero;
      side0_in.root = in_data.base.root;
      side0_in.neg  = '0;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod_ff    <= prod_in;
         side_ff[0] <= side0_in;
      end
   end

   // magnitude and sign
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         neg_in[l] = prod_ff[l][ProdW-1];
         abs_in[l] = neg_in[l] ? -prod_ff[l] : prod_ff[l];
      end
      side1_in     = side_ff[0];
      side1_in.neg = neg_in;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         for (int l = 0; l < 3; l++) begin
            mag_ff[l] <= abs_in[l][ProdW-2:0];
         end
         side_ff[1] <= side1_in;
      end
   end

   // round to nearest, scale down by 2^12, split off the first remainder
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         nsum[l] = {1'b0, mag_ff[l]} + ProdW'({side_ff[1].root, 11'h000});
         dvd[l]  = nsum[l][12+DvdW-1:12];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         for (int l = 0; l < 3; l++) begin
            rem_ff[0][l] <= RootW'(dvd[l][DvdW-1:QuoW]);
            dq_ff[0][l]  <= dvd[l][QuoW-1:0];
         end
         side_ff[2] <= side_ff[1];
      end
   end

   // one quotient bit per stage
   for (genvar j = 1; j <= QuoW; j++) begin : g_quo
      logic [RootW:0]   rem_sh [3];
      logic [RootW:0]   rem_in [3];
      logic [2:0]       take;
      always_comb begin
         for (int l = 0; l < 3; l++) begin
            rem_sh[l] = {rem_ff[j-1][l], dq_ff[j-1][l][QuoW-1]};
            take[l]   = (rem_sh[l] >= {1'b0, side_ff[j+1].root});
            rem_in[l] = take[l] ? rem_sh[l] - {1'b0, side_ff[j+1].root} : rem_sh[l];
         end
      end
      always_ff @(posedge clock) begin
         if (stage_en[j+2]) begin
            for (int l = 0; l < 3; l++) begin
               rem_ff[j][l] <= rem_in[l][RootW-1:0];
               dq_ff[j][l]  <= {dq_ff[j-1][l][QuoW-2:0], take[l]};
            end
            side_ff[j+2] <= side_ff[j+1];
         end
      end
   end

   // sign, clamp, identity for the zero vector
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         sq[l] = side_ff[QuoW+2].neg[l] ? -$signed({1'b0, dq_ff[QuoW][l]})
                                         : $signed({1'b0, dq_ff[QuoW][l]});
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[NStg-1]) begin
         if (side_ff[QuoW+2].zero) begin
            res_ff.quat_w <= RotW'(OneQ14);
            res_ff.quat_x <= '0;
            res_ff.quat_y <= '0;
            res_ff.quat_z <= '0;
         end else begin
            res_ff.quat_w <= side_ff[QuoW+2].w;
            res_ff.quat_x <= sat_q14(AngW'(sq[0]));
            res_ff.quat_y <= sat_q14(AngW'(sq[1]));
            res_ff.quat_z <= sat_q14(AngW'(sq[2]));
         end
      end
   end

   assign out_valid = valid_ff[NStg-1];
   assign out_data  = res_ff;

`ifndef SYNTHESIS
   a_first_rem: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[2] && !side_ff[2].zero) |->
         (rem_ff[0][0] < side_ff[2].root && rem_ff[0][1] < side_ff[2].root &&
          rem_ff[0][2] < side_ff[2].root))
      else $error("quotient overflows divider width");
`endif

endmodule

@@ bench/rotation_vector_to_quaternion_unit_tb.sv @@
`timescale 1ns / 1ps
module rotation_vector_to_quaternion_unit_tb;
   import rvq_pkg::*;

   localparam int Stages = 16;
   localparam int Latency = 46 + Stages;
   localparam longint PiVal = 64'd3373259426;
   localparam longint HalfPiVal = 64'd1686629713;
   localparam longint TwoPiVal = 64'd6746518852;
   localparam longint GainInv = 64'h26DD3B6A;

   class quat_scoreboard;
      rsp_payload_type pending[$];
      int errors;

      function automatic longint floor_shift(longint v, int s);
         return v >>> s;
      endfunction

      function automatic longint int_root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function automatic longint clamp_q14(longint v);
         if (v > OneQ14) return OneQ14;
         if (v < -OneQ14) return -OneQ14;
         return v;
      endfunction

      function automatic longint round_div(longint num, longint den);
         longint m, q;
         m = (num < 0) ? -num : num;
         q = (m + den / 2) / den;
         return (num < 0) ? -q : q;
      endfunction

      function automatic rsp_payload_type to_quat(req_payload_type r);
         rsp_payload_type q;
         longint v[3];
         longint sq, t, h, cx, cy, cz, dx, dy, den;
         bit flip;
         v[0] = r.rot_x;
         v[1] = r.rot_y;
         v[2] = r.rot_z;
         sq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
         if (sq == 0) begin
            q.quat_w = RotW'(OneQ14);
            q.quat_x = '0;
            q.quat_y = '0;
            q.quat_z = '0;
            return q;
         end
         t = int_root(sq << 8);
         h = t << 13;
         flip = 0;
         if (h > PiVal) h = h - TwoPiVal;
         if (h > HalfPiVal) begin
            h = h - PiVal;
            flip = 1;
         end else if (h < -HalfPiVal) begin
            h = h + PiVal;
            flip = 1;
         end
         cx = GainInv;
         cy = 0;
         cz = h;
         for (int i = 0; i < Stages && i < AtanEntries; i++) begin
            dx = floor_shift(cy, i);
            dy = floor_shift(cx, i);
            if (cz >= 0) begin
               cx = cx - dx;
               cy = cy + dy;
               cz = cz - longint'(AtanTable[i]);
            end else begin
               cx = cx + dx;
               cy = cy - dy;
               cz = cz + longint'(AtanTable[i]);
            end
         end
         if (flip) begin
            cx = -cx;
            cy = -cy;
         end
         den = t << 12;
         q.quat_w = RotW'(clamp_q14(floor_shift(cx + 32768, 16)));
         q.quat_x = RotW'(clamp_q14(round_div(v[0] * cy, den)));
         q.quat_y = RotW'(clamp_q14(round_div(v[1] * cy, den)));
         q.quat_z = RotW'(clamp_q14(round_div(v[2] * cy, den)));
         return q;
      endfunction

      function void note_request(req_payload_type r);
         pending.push_back(to_quat(r));
      endfunction

      function void check_quat(rsp_payload_type got);
         rsp_payload_type exp_q;
         if (pending.size() == 0) begin
            $display("%0t unexpected response %h", $realtime, got);
            errors++;
            return;
         end
         exp_q = pending.pop_front();
         if (got.quat_w !== exp_q.quat_w) begin
            $display("%0t quat_w exp %0d got %0d", $realtime, exp_q.quat_w, got.quat_w);
            errors++;
         end
         if (got.quat_x !== exp_q.quat_x) begin
            $display("%0t quat_x exp %0d got %0d", $realtime, exp_q.quat_x, got.quat_x);
            errors++;
         end
         if (got.quat_y !== exp_q.quat_y) begin
            $display("%0t quat_y exp %0d got %0d", $realtime, exp_q.quat_y, got.quat_y);
            errors++;
         end
         if (got.quat_z !== exp_q.quat_z) begin
            $display("%0t quat_z exp %0d got %0d", $realtime, exp_q.quat_z, got.quat_z);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_payload_type rsp_data;

   quat_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   longint cycles = 0;

   rotation_vector_to_quaternion_unit #(.CORDIC_STAGES(Stages)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) board.check_quat(rsp_data);
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
   end

   task automatic send_vec(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= '{rot_x: x, rot_y: y, rot_z: z};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(req_data);
      @(negedge clock);
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(5))
         0: return 16'($urandom_range(65535));
         1: return 16'($signed($urandom_range(16)) - 8);
         2: return 16'($signed($urandom_range(8000)) - 4000);
         3: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         4: return 16'(1 << $urandom_range(15));
         default: return 16'($signed($urandom_range(30000)) - 15000);
      endcase
   endfunction

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   initial begin
      logic [15:0] ext[8];
      ext = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
              16'h8000, 16'h1000, 16'hF000, 16'h3244};
      repeat (4) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      for (int i = 0; i < 8; i++) send_vec(ext[i], ext[(i + 3) % 8], ext[(i + 5) % 8]);
      send_vec(16'h0000, 16'h0000, 16'h0000);
      send_vec(16'h8000, 16'h8000, 16'h8000);
      send_vec(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_vec(16'h3244, 16'h0000, 16'h0000);
      send_vec(16'h6488, 16'h0000, 16'h0000);
      send_vec(16'hCDBC, 16'h0000, 16'h0000);
      send_vec(16'h0000, 16'h1922, 16'h0000);
      send_vec(16'h0000, 16'h0000, 16'h9B78);
      send_vec(16'hAAAA, 16'h5555, 16'h0000);
      drain();
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 73 : 0;
         recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 16 : 0;
         for (int n = 0; n < 217; n++) begin
            send_vec(rand_comp(), rand_comp(), rand_comp());
            if (n == 100) drain();
         end
      end
      drain();
      repeat (Latency + 20) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

@@ rotation_vector_to_quaternion_unit.f @@
rtl/rvq_pkg.sv
rtl/rvq_sqrt.sv
rtl/rvq_cordic.sv
rtl/rvq_div.sv
rtl/rotation_vector_to_quaternion_unit.sv
bench/rotation_vector_to_quaternion_unit_tb.sv
